@@ rtl/ihex_pkg.sv @@
package ihex_pkg;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;
    localparam logic [7:0] HEX_TEN    = 8'h0A;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_ESA  = 8'h02;
    localparam logic [7:0] REC_SSA  = 8'h03;
    localparam logic [7:0] REC_ELA  = 8'h04;
    localparam logic [7:0] REC_SLA  = 8'h05;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_COLON = 3'd1;
    localparam logic [2:0] ST_LENGTH   = 3'd2;
    localparam logic [2:0] ST_CHECKSUM = 3'd3;
    localparam logic [2:0] ST_ESA_BAD  = 3'd4;
    localparam logic [2:0] ST_ELA_BAD  = 3'd5;
    localparam logic [2:0] ST_SSA_BAD  = 3'd6;
    localparam logic [2:0] ST_SLA_BAD  = 3'd7;

    localparam logic       KIND_DATA   = 1'b0;
    localparam logic       KIND_STATUS = 1'b1;

    localparam logic [9:0] POS_MAX = 10'd1023;

    localparam int TDATA_BITS = 88;

    typedef struct packed {
        logic        kind;
        logic [31:0] byte_address;
        logic [7:0]  byte_value;
        logic [2:0]  line_status;
        logic [7:0]  record_kind;
        logic [31:0] start_value;
    } t_result;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                v = c - CHAR_ZERO;
            end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
                v = c - CHAR_LC_A + HEX_TEN;
            end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
                v = c - CHAR_UC_A + HEX_TEN;
            end
            hex_value = v[3:0];
        end
    endfunction

endpackage

@@ rtl/ihex_line_core.sv @@
module ihex_line_core
    import ihex_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_char,
    input  logic       i_line_end,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [9:0]  r_pos, n_pos;
    logic        r_colon, n_colon;
    logic [3:0]  r_high, n_high;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_offset, n_offset;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_sum, n_sum;
    logic [31:0] r_lead, n_lead;
    logic [16:0] r_didx, n_didx;
    logic [7:0]  r_cksum, n_cksum;
    logic [31:0] r_base, n_base;
    logic [31:0] r_start_seg, n_start_seg;
    logic [31:0] r_start_lin, n_start_lin;

    logic [9:0]  w_base_len;
    logic [7:0]  w_byte;
    logic [8:0]  w_pair;
    logic [8:0]  w_pair_end;
    logic [2:0]  w_status;
    logic        w_form_ok;

    always_comb begin
        n_pos       = r_pos;
        n_colon     = r_colon;
        n_high      = r_high;
        n_count     = r_count;
        n_offset    = r_offset;
        n_type      = r_type;
        n_sum       = r_sum;
        n_lead      = r_lead;
        n_didx      = r_didx;
        n_cksum     = r_cksum;
        n_base      = r_base;
        n_start_seg = r_start_seg;
        n_start_lin = r_start_lin;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.record_kind = r_type;

        w_base_len = {1'b0, r_count, 1'b0} + 10'd11;
        w_byte     = {r_high, hex_value(i_char)};
        w_pair     = r_pos[9:1] - 9'd1;
        w_pair_end = 9'd4 + {1'b0, r_count};
        w_form_ok  = (r_offset == 16'd0);
        w_status   = ST_OK;

        if (i_line_end) begin
            if (!r_colon) begin
                w_status = ST_NO_COLON;
            end else if (r_pos != w_base_len && r_pos != w_base_len + 10'd1) begin
                w_status = ST_LENGTH;
            end else if (8'(9'h100 - {1'b0, r_sum}) != r_cksum) begin
                w_status = ST_CHECKSUM;
            end else if (r_type == REC_ESA || r_type == REC_ELA) begin
                if (!w_form_ok || r_count != 8'd2) begin
                    w_status = (r_type == REC_ESA) ? ST_ESA_BAD : ST_ELA_BAD;
                end else if (r_type == REC_ESA) begin
                    n_base = {12'd0, r_lead[15:0], 4'd0};
                end else begin
                    n_base = {r_lead[15:0], 16'd0};
                end
            end else if (r_type == REC_SSA || r_type == REC_SLA) begin
                if (!w_form_ok || r_count != 8'd4) begin
                    w_status = (r_type == REC_SSA) ? ST_SSA_BAD : ST_SLA_BAD;
                end else if (r_type == REC_SSA) begin
                    n_start_seg = r_lead;
                end else begin
                    n_start_lin = r_lead;
                end
            end
            if (w_status >= ST_CHECKSUM) begin
                n_base = 32'd0;
            end
            o_res_valid       = 1'b1;
            o_res.kind        = KIND_STATUS;
            o_res.line_status = w_status;
            o_res.start_value = (r_type == REC_SSA) ? n_start_seg
                              : (r_type == REC_SLA) ? n_start_lin : 32'd0;
            n_pos    = 10'd0;
            n_colon  = 1'b0;
            n_high   = 4'd0;
            n_count  = 8'd0;
            n_offset = 16'd0;
            n_type   = 8'd0;
            n_sum    = 8'd0;
            n_lead   = 32'd0;
            n_didx   = 17'd0;
            n_cksum  = 8'd0;
        end else begin
            if (r_pos == 10'd0) begin
                n_colon = (i_char == CHAR_COLON);
            end else if (r_pos[0]) begin
                n_high = hex_value(i_char);
            end else begin
                if (w_pair == 9'd0) begin
                    n_count = w_byte;
                    n_sum   = r_sum + w_byte;
                end else if (w_pair == 9'd1) begin
                    n_offset = {w_byte, r_offset[7:0]};
                    n_sum    = r_sum + w_byte;
                end else if (w_pair == 9'd2) begin
                    n_offset = {r_offset[15:8], w_byte};
                    n_sum    = r_sum + w_byte;
                end else if (w_pair == 9'd3) begin
                    n_type = w_byte;
                    n_sum  = r_sum + w_byte;
                end else if (w_pair < w_pair_end) begin
                    n_sum  = r_sum + w_byte;
                    n_lead = {r_lead[23:0], w_byte};
                    if (r_colon && r_type == REC_DATA) begin
                        o_res_valid        = 1'b1;
                        o_res.kind         = KIND_DATA;
                        o_res.byte_address = r_base + {16'd0, r_offset} + {15'd0, r_didx};
                        o_res.byte_value   = w_byte;
                    end
                    n_didx = r_didx + 17'd1;
                end else if (w_pair == w_pair_end) begin
                    n_cksum = w_byte;
                end
            end
            if (r_pos < POS_MAX) begin
                n_pos = r_pos + 10'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 10'd0;
            r_colon     <= 1'b0;
            r_high      <= 4'd0;
            r_count     <= 8'd0;
            r_offset    <= 16'd0;
            r_type      <= 8'd0;
            r_sum       <= 8'd0;
            r_lead      <= 32'd0;
            r_didx      <= 17'd0;
            r_cksum     <= 8'd0;
            r_base      <= 32'd0;
            r_start_seg <= 32'd0;
            r_start_lin <= 32'd0;
        end else if (i_step) begin
            r_pos       <= n_pos;
            r_colon     <= n_colon;
            r_high      <= n_high;
            r_count     <= n_count;
            r_offset    <= n_offset;
            r_type      <= n_type;
            r_sum       <= n_sum;
            r_lead      <= n_lead;
            r_didx      <= n_didx;
            r_cksum     <= n_cksum;
            r_base      <= n_base;
            r_start_seg <= n_start_seg;
            r_start_lin <= n_start_lin;
        end
    end

endmodule

@@ rtl/ihex_out_stage.sv @@
module ihex_out_stage
    import ihex_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid, n_valid;
    t_result r_res;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ rtl/intel_hex_record_decoder.sv @@
// Intel HEX line decoder.
// The slave channel takes one ASCII character per item in tdata; an item
// with tlast high ends the line and its tdata is ignored.
// The master channel gives results. tuser is 0 for a provisional data byte
// write (address and byte value) and 1 for the status of a finished line
// (status code, record type and start address for start records).
// Each character passes an input register and then the decode logic, whose
// result lands in the output register. Characters that give no result
// simply pass through.
// One item is accepted every clock while the output register is empty or
// being read; throughput is one item per cycle, set by the single decode
// step between the two registers.
// When the receiver stalls with a result pending, the input register holds
// one more item and then tready falls until the result is taken.
// Reset clears the line state, the segment base and both start addresses,
// and empties both registers.
module intel_hex_record_decoder
    import ihex_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,  // char_code
    input  logic                  i_s_axis_tlast,  // line_end
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // byte_address[31:0], byte_value[39:32], line_status[42:40],
    // record_kind[50:43], start_value[82:51], zero fill above
    output logic [TDATA_BITS-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tuser   // kind
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       w_out_free;
    logic       w_step;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_out;

    assign w_out_free      = !o_m_axis_tvalid || i_m_axis_tready;
    assign w_step          = r_in_valid && w_out_free;
    assign o_s_axis_tready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_char <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    ihex_line_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_char     (r_in_char),
        .i_line_end (r_in_last),
        .o_res_valid(w_res_valid),
        .o_res      (w_res)
    );

    ihex_out_stage u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (w_step && w_res_valid),
        .i_res  (w_res),
        .i_ready(i_m_axis_tready),
        .o_valid(o_m_axis_tvalid),
        .o_res  (w_out)
    );

    assign o_m_axis_tuser = w_out.kind;
    assign o_m_axis_tdata = {5'd0, w_out.start_value, w_out.record_kind,
                             w_out.line_status, w_out.byte_value, w_out.byte_address};

endmodule

@@ tb/tb_intel_hex_record_decoder.sv @@
`timescale 1ns / 1ps

module tb_intel_hex_record_decoder;
    import ihex_pkg::*;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_char_item;

    typedef enum int {
        FLAW_NONE,
        FLAW_NO_COLON,
        FLAW_EXTRA_ONE,
        FLAW_EXTRA_MANY,
        FLAW_DROP,
        FLAW_NOISE,
        FLAW_SUM
    } t_flaw;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = 8'd0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;
    logic                  m_tuser;

    t_char_item char_queue[$];
    t_result    awaited_results[$];
    logic [7:0] line_bytes[$];
    int         n_chars = 0;
    int         errors = 0;

    // Decoder state mirrored at the block's widths.
    logic [9:0]  ln_pos;
    logic        ln_colon;
    logic [3:0]  ln_high;
    logic [7:0]  ln_count;
    logic [15:0] ln_offset;
    logic [7:0]  ln_type;
    logic [7:0]  ln_sum;
    logic [31:0] ln_lead;
    logic [16:0] ln_index;
    logic [7:0]  ln_csum;
    logic [31:0] seg_base;
    logic [31:0] start_seg;
    logic [31:0] start_lin;

    intel_hex_record_decoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [3:0] digit_of(input logic [7:0] c);
        logic [7:0] folded;
        logic [7:0] d;
        folded = c | 8'h20;
        d = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
        end else if (folded >= CHAR_LC_A && folded <= CHAR_LC_F) begin
            d = folded - CHAR_LC_A + HEX_TEN;
        end
        return d[3:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
        if (n < 4'd10) begin
            return CHAR_ZERO + 8'(n);
        end
        return (lower ? CHAR_LC_A : CHAR_UC_A) + 8'(n) - HEX_TEN;
    endfunction

    task automatic clear_line_state();
        ln_pos = '0;
        ln_colon = 1'b0;
        ln_high = '0;
        ln_count = '0;
        ln_offset = '0;
        ln_type = '0;
        ln_sum = '0;
        ln_lead = '0;
        ln_index = '0;
        ln_csum = '0;
    endtask

    task automatic track_char(input logic [7:0] c, input logic last);
        t_result    r;
        logic [2:0] st;
        logic [7:0] b;
        int         blen;
        int         pair;
        r = '0;
        if (last) begin
            st = ST_OK;
            blen = 2 * int'(ln_count) + 11;
            if (!ln_colon) begin
                st = ST_NO_COLON;
            end else if (int'(ln_pos) != blen && int'(ln_pos) != blen + 1) begin
                st = ST_LENGTH;
            end else if (8'(8'h00 - ln_sum) != ln_csum) begin
                st = ST_CHECKSUM;
            end else if (ln_type == REC_ESA || ln_type == REC_ELA) begin
                if (ln_offset != 16'd0 || ln_count != 8'd2) begin
                    st = (ln_type == REC_ESA) ? ST_ESA_BAD : ST_ELA_BAD;
                end else if (ln_type == REC_ESA) begin
                    seg_base = {12'd0, ln_lead[15:0], 4'd0};
                end else begin
                    seg_base = {ln_lead[15:0], 16'd0};
                end
            end else if (ln_type == REC_SSA || ln_type == REC_SLA) begin
                if (ln_offset != 16'd0 || ln_count != 8'd4) begin
                    st = (ln_type == REC_SSA) ? ST_SSA_BAD : ST_SLA_BAD;
                end else if (ln_type == REC_SSA) begin
                    start_seg = ln_lead;
                end else begin
                    start_lin = ln_lead;
                end
            end
            if (st >= ST_CHECKSUM) begin
                seg_base = '0;
            end
            r.kind = KIND_STATUS;
            r.line_status = st;
            r.record_kind = ln_type;
            r.start_value = (ln_type == REC_SSA) ? start_seg :
                            (ln_type == REC_SLA) ? start_lin : 32'd0;
            awaited_results.push_back(r);
            clear_line_state();
        end else begin
            if (ln_pos == 10'd0) begin
                ln_colon = (c == CHAR_COLON);
            end else if (ln_pos[0]) begin
                ln_high = digit_of(c);
            end else begin
                b = {ln_high, digit_of(c)};
                pair = int'(ln_pos) / 2 - 1;
                if (pair == 0) begin
                    ln_count = b;
                    ln_sum = ln_sum + b;
                end else if (pair == 1) begin
                    ln_offset[15:8] = b;
                    ln_sum = ln_sum + b;
                end else if (pair == 2) begin
                    ln_offset[7:0] = b;
                    ln_sum = ln_sum + b;
                end else if (pair == 3) begin
                    ln_type = b;
                    ln_sum = ln_sum + b;
                end else if (pair < 4 + int'(ln_count)) begin
                    ln_sum = ln_sum + b;
                    ln_lead = {ln_lead[23:0], b};
                    if (ln_colon && ln_type == REC_DATA) begin
                        r.kind = KIND_DATA;
                        r.byte_address = seg_base + 32'(ln_offset) + 32'(ln_index);
                        r.byte_value = b;
                        r.record_kind = ln_type;
                        awaited_results.push_back(r);
                    end
                    ln_index = ln_index + 17'd1;
                end else if (pair == 4 + int'(ln_count)) begin
                    ln_csum = b;
                end
            end
            if (ln_pos < POS_MAX) begin
                ln_pos = ln_pos + 10'd1;
            end
        end
    endtask

    task automatic put_char(input logic [7:0] c, input logic last);
        char_queue.push_back('{code: c, last: last});
        n_chars++;
    endtask

    task automatic put_line_end();
        put_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Sends line_bytes as one record, with its checksum and the given flaw.
    task automatic send_record(input t_flaw flaw);
        logic [7:0] chars[$];
        logic [7:0] sum;
        logic [7:0] lead;
        logic       lower;
        int         k;
        int         extra;
        sum = '0;
        foreach (line_bytes[k]) begin
            sum = sum + line_bytes[k];
        end
        if (flaw == FLAW_SUM) begin
            line_bytes.push_back(8'h00 - sum + 8'($urandom_range(1, 255)));
        end else begin
            line_bytes.push_back(8'h00 - sum);
        end
        lower = 1'($urandom_range(0, 1));
        lead = CHAR_COLON;
        if (flaw == FLAW_NO_COLON) begin
            lead = 8'($urandom_range(0, 255));
            if (lead == CHAR_COLON) begin
                lead = CHAR_ZERO;
            end
        end
        chars.push_back(lead);
        foreach (line_bytes[k]) begin
            chars.push_back(hex_char(line_bytes[k][7:4], lower));
            chars.push_back(hex_char(line_bytes[k][3:0], lower));
        end
        case (flaw)
            FLAW_EXTRA_ONE: begin
                chars.push_back(8'($urandom_range(0, 255)));
            end
            FLAW_EXTRA_MANY: begin
                extra = $urandom_range(2, 5);
                for (k = 0; k < extra; k++) begin
                    chars.push_back(8'($urandom_range(0, 255)));
                end
            end
            FLAW_DROP: begin
                void'(chars.pop_back());
            end
            FLAW_NOISE: begin
                chars[$urandom_range(1, chars.size() - 1)] = 8'($urandom_range(0, 255));
            end
            default: begin
            end
        endcase
        foreach (chars[k]) begin
            put_char(chars[k], 1'b0);
        end
        put_line_end();
    endtask

    // With count at most 4 the data bytes come from payload, big-endian; else they are random.
    task automatic make_record(input logic [7:0] cnt, input logic [15:0] off,
                               input logic [7:0] typ, input logic [31:0] payload,
                               input t_flaw flaw);
        int i;
        line_bytes.delete();
        line_bytes.push_back(cnt);
        line_bytes.push_back(off[15:8]);
        line_bytes.push_back(off[7:0]);
        line_bytes.push_back(typ);
        for (i = 0; i < int'(cnt); i++) begin
            if (cnt <= 8'd4) begin
                line_bytes.push_back(8'(payload >> (8 * (int'(cnt) - 1 - i))));
            end else begin
                line_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        send_record(flaw);
    endtask

    task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
        end
    endtask

    // Sender: bursts of random length with random gaps between them.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                void'(char_queue.pop_front());
            end
            if (!(s_tvalid && !s_tready)) begin
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (char_queue.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= char_queue[0].code;
                    s_tlast <= char_queue[0].last;
                    burst_left--;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: rotates through four stall modes: always ready, random ready, a repeating pattern, random stalls.
    int rx_cycle = 0;
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_cycle = 0;
            stall_left = 0;
        end else begin
            rx_cycle++;
            case ((rx_cycle / 300) % 4)
                0: begin
                    m_tready <= 1'b1;
                end
                1: begin
                    m_tready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_tready <= ((rx_cycle % 7) >= 3);
                end
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        m_tready <= 1'b0;
                    end else begin
                        if ($urandom_range(0, 11) == 0) begin
                            stall_left = $urandom_range(4, 30);
                        end
                        m_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            clear_line_state();
            seg_base = '0;
            start_seg = '0;
            start_lin = '0;
            awaited_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual kind %b data %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    exp_r = awaited_results.pop_front();
                    check_field("kind", 32'(exp_r.kind), 32'(m_tuser));
                    check_field("byte_address", exp_r.byte_address, m_tdata[31:0]);
                    check_field("byte_value", 32'(exp_r.byte_value), 32'(m_tdata[39:32]));
                    check_field("line_status", 32'(exp_r.line_status), 32'(m_tdata[42:40]));
                    check_field("record_kind", 32'(exp_r.record_kind), 32'(m_tdata[50:43]));
                    check_field("start_value", exp_r.start_value, m_tdata[82:51]);
                    check_field("zero_fill", 32'd0, 32'(m_tdata[TDATA_BITS-1:83]));
                end
            end
            if (s_tvalid && s_tready) begin
                track_char(s_tdata, s_tlast);
            end
        end
    end

    initial begin
        #20_000_000;
        $display("[intel_hex_record_decoder] ERROR");
        $finish;
    end

    initial begin
        int          r;
        int          i;
        int          len;
        int          target;
        logic [7:0]  cnt;
        logic [7:0]  typ;
        logic [15:0] off;
        t_flaw       flaw;

        make_record(8'd0, 16'h0000, 8'h01, 32'd0, FLAW_NONE);
        make_record(8'd2, 16'hFFFF, REC_DATA, 32'h0000_00FF, FLAW_NONE);
        make_record(8'd2, 16'h0000, REC_ELA, 32'h0000_FFFF, FLAW_NONE);
        // Address wraps past the top of the 32-bit space.
        make_record(8'd3, 16'hFFFE, REC_DATA, 32'h00A5_5A3C, FLAW_NONE);
        make_record(8'd2, 16'h0000, REC_ESA, 32'h0000_1234, FLAW_NONE);
        make_record(8'd4, 16'h0010, REC_DATA, 32'hDEAD_BEEF, FLAW_EXTRA_ONE);
        make_record(8'd4, 16'h0000, REC_SSA, 32'h1234_5678, FLAW_NONE);
        make_record(8'd4, 16'h0000, REC_SLA, 32'hFFFF_FFFF, FLAW_NONE);
        make_record(8'd4, 16'h0000, REC_SLA, 32'h0000_0000, FLAW_NONE);
        make_record(8'd3, 16'h0000, REC_ESA, 32'h0001_0000, FLAW_NONE);
        make_record(8'd2, 16'h0000, REC_ELA, 32'h0000_8000, FLAW_NONE);
        make_record(8'd2, 16'h0001, REC_ELA, 32'h0000_4321, FLAW_NONE);
        make_record(8'd2, 16'h0000, REC_SSA, 32'h0000_ABCD, FLAW_NONE);
        make_record(8'd4, 16'h8000, REC_SLA, 32'h0102_0304, FLAW_NONE);
        make_record(8'd2, 16'h0000, REC_ELA, 32'h0000_0001, FLAW_NONE);
        make_record(8'd1, 16'h0040, REC_DATA, 32'h0000_0077, FLAW_SUM);
        make_record(8'd2, 16'h0000, REC_ESA, 32'h0000_F000, FLAW_NONE);
        make_record(8'd2, 16'h0020, REC_DATA, 32'h0000_1122, FLAW_NO_COLON);
        make_record(8'd2, 16'h0030, REC_DATA, 32'h0000_3344, FLAW_DROP);
        make_record(8'd2, 16'h0040, REC_DATA, 32'h0000_5566, FLAW_EXTRA_MANY);
        make_record(8'd4, 16'h0050, REC_DATA, 32'h6677_8899, FLAW_NOISE);
        put_line_end();
        make_record(8'd3, 16'h1234, 8'hFF, 32'h00AB_CDEF, FLAW_NONE);
        make_record(8'd255, 16'hFF00, REC_DATA, 32'd0, FLAW_NONE);

        target = 1350;
        while (n_chars < target) begin
            r = $urandom_range(0, 99);
            flaw = ($urandom_range(0, 3) == 0) ? t_flaw'($urandom_range(1, 6)) : FLAW_NONE;
            if (r < 4) begin
                len = $urandom_range(0, 30);
                for (i = 0; i < len; i++) begin
                    put_char(8'($urandom_range(0, 255)), 1'b0);
                end
                put_line_end();
            end else begin
                if (r < 55) begin
                    typ = REC_DATA;
                    cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(9, 40)) :
                                                        8'($urandom_range(0, 8));
                    off = 16'($urandom_range(0, 65535));
                end else if (r < 85) begin
                    case ($urandom_range(0, 3))
                        0: typ = REC_ESA;
                        1: typ = REC_ELA;
                        2: typ = REC_SSA;
                        default: typ = REC_SLA;
                    endcase
                    if ($urandom_range(0, 6) != 0) begin
                        cnt = (typ == REC_ESA || typ == REC_ELA) ? 8'd2 : 8'd4;
                    end else begin
                        cnt = 8'($urandom_range(0, 6));
                    end
                    off = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 65535)) : 16'd0;
                end else if (r < 91) begin
                    typ = 8'h01;
                    cnt = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 4)) : 8'd0;
                    off = '0;
                end else begin
                    typ = 8'($urandom_range(0, 255));
                    cnt = 8'($urandom_range(0, 6));
                    off = 16'($urandom_range(0, 65535));
                end
                make_record(cnt, off, typ, $urandom, flaw);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_queue.size() != 0 || s_tvalid) begin
            @(posedge i_clk);
        end
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);

        if (errors == 0) begin
            $display("[intel_hex_record_decoder] OK");
        end else begin
            $display("[intel_hex_record_decoder] ERROR");
        end
        $finish;
    end

endmodule
